FILE: rtl/core/lms_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian mesh smoothing package
// Shared codes, field widths and the controller/datapath command types.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 32;
    localparam int IDX_W    = 12;
    localparam int VCNT_W   = 13;
    localparam int TCNT_W   = 14;
    localparam int FACT_W   = 17;
    localparam int ITER_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADDV  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADDT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_VFULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TFULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADCORN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADREAD  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER   = 1'd1;

    // Phase the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_CLR   = 4'd1,
        OP_TRI   = 4'd2,
        OP_UPD   = 4'd3
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       start;
    } dp_cmd_t;

    typedef struct packed {
        logic       done;
    } dp_stat_t;

endpackage

FILE: rtl/core/lms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/lms_div.sv
// ----------------------------------------------------------------------------
// Mesh smoothing divider
// Restoring signed division truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lms_div #(
    parameter int NW = 40,
    parameter int DW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg, q_next;
    logic [DW:0]    r_reg, r_next;
    logic [DW-1:0]  d_reg, d_next;
    logic           neg_reg, neg_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DW+1:0]  trial;
    logic [NW-1:0]  mag;

    assign mag = num[NW-1] ? (~num + 1'b1) : num;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = mag;
            r_next    = '0;
            d_next    = den;
            neg_next  = num[NW-1];
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[NW-1]} - {2'b00, d_reg};
            if (!trial[DW+1])
            begin
                r_next = trial[DW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

FILE: rtl/core/lms_datapath.sv
// ----------------------------------------------------------------------------
// Mesh smoothing datapath
// Runs one pass phase at a time: sum clearing, triangle scan, vertex update.
// ----------------------------------------------------------------------------
module lms_datapath #(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_TRIANGLES = 8192,
    parameter int SUM_WIDTH     = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lms_pkg::dp_cmd_t             cmd,
    output lms_pkg::dp_stat_t            stat,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]  vcount,
    input  logic [$clog2(MAX_TRIANGLES+1)-1:0] tcount,
    input  logic [lms_pkg::FACT_W-1:0]   factor,
    // vertex memory access (owned here while a phase runs)
    output logic                         vs_we,
    output logic [$clog2(MAX_VERTICES)-1:0] vs_waddr,
    output logic [3*lms_pkg::POS_W-1:0]  vs_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0] vs_raddr,
    input  logic [3*lms_pkg::POS_W-1:0]  vs_rdata,
    input  logic                         mark_rdata,
    output logic [$clog2(MAX_TRIANGLES)-1:0] ts_raddr,
    input  logic [3*lms_pkg::IDX_W-1:0]  ts_rdata,
    output logic                         busy
);

    localparam int VA  = $clog2(MAX_VERTICES);
    localparam int TA  = $clog2(MAX_TRIANGLES);
    localparam int TC  = $clog2(MAX_TRIANGLES + 1);
    localparam int CNW = TC + 3;            // neighbour count width
    localparam int SW  = SUM_WIDTH;
    localparam int NBW = 3 * SW + CNW;
    localparam int PW  = lms_pkg::POS_W;
    localparam int FW  = lms_pkg::FACT_W;
    localparam int DVW = (SW > CNW) ? SW : CNW;

    // Neighbour sum memory, cleared by a sweep at the start of each pass.
    logic           nb_we;
    logic [VA-1:0]  nb_waddr, nb_raddr;
    logic [NBW-1:0] nb_wdata, nb_rdata;

    lms_ram #(.WIDTH(NBW), .DEPTH(MAX_VERTICES)) u_nb_ram (
        .clk  (clk),
        .we   (nb_we),
        .waddr(nb_waddr),
        .wdata(nb_wdata),
        .raddr(nb_raddr),
        .rdata(nb_rdata)
    );

    // Triangle scan: per triangle read corners, then 6 directed edges.
    // Each edge: read self sum and other position, add, write; an edge with equal corners is skipped.
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CLR    = 10'b0000000010,
        S_TRD    = 10'b0000000100,
        S_TWAIT  = 10'b0000001000,
        S_EREQ   = 10'b0000010000,
        S_EWAIT  = 10'b0000100000,
        S_EADD   = 10'b0001000000,
        S_UREQ   = 10'b0010000000,
        S_UWAIT  = 10'b0100000000,
        S_UCALC  = 10'b1000000000
    } ph_t;

    ph_t              st_reg, st_next;
    logic [TC-1:0]    i_reg, i_next;
    logic [2:0]       e_reg, e_next;
    logic [3*lms_pkg::IDX_W-1:0] tri_reg, tri_next;
    logic [1:0]       ax_reg, ax_next;
    logic [2:0]       us_reg, us_next;
    logic signed [PW-1:0] oldp_reg, oldp_next;
    logic signed [FW+PW+2:0] prod_reg, prod_next;
    logic [3*PW-1:0]  newp_reg, newp_next;
    logic             done_reg, done_next;

    logic [lms_pkg::IDX_W-1:0] self_i, oth_i, cor [3];
    logic [1:0] sk, om;

    always_comb
    begin
        cor[0] = tri_reg[lms_pkg::IDX_W-1:0];
        cor[1] = tri_reg[2*lms_pkg::IDX_W-1:lms_pkg::IDX_W];
        cor[2] = tri_reg[3*lms_pkg::IDX_W-1:2*lms_pkg::IDX_W];
        case (e_reg)
            3'd0:    begin sk = 2'd0; om = 2'd1; end
            3'd1:    begin sk = 2'd0; om = 2'd2; end
            3'd2:    begin sk = 2'd1; om = 2'd0; end
            3'd3:    begin sk = 2'd1; om = 2'd2; end
            3'd4:    begin sk = 2'd2; om = 2'd0; end
            default: begin sk = 2'd2; om = 2'd1; end
        endcase
        self_i = cor[sk];
        oth_i  = cor[om];
    end

    // Saturating sum of one axis.
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [PW-1:0] p);
        logic signed [SW:0] w;
        w = $signed({s[SW-1], s}) + (SW+1)'($signed(p));
        if (w[SW] != w[SW-1])
        begin
            sat_add = w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sat_add = w[SW-1:0];
        end
    endfunction

    // Divider for averages.
    logic            dv_start, dv_done;
    logic signed [DVW-1:0] dv_num, dv_quo;

    lms_div #(.NW(DVW), .DW(CNW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(dv_start),
        .num  (dv_num),
        .den  (nb_rdata[NBW-1:3*SW]),
        .done (dv_done),
        .quo  (dv_quo)
    );

    logic signed [PW:0]      diff;
    logic signed [FW+PW+2:0] stepv;
    logic signed [PW+1:0]    newv;
    logic [PW-1:0]           newsat;

    assign dv_num = DVW'($signed(nb_rdata[ax_reg*SW +: SW]));
    assign diff   = (PW+1)'($signed(dv_quo)) - (PW+1)'($signed(oldp_reg));

    always_comb
    begin
        // truncation toward zero of prod / 65536
        if (prod_reg[FW+PW+2])
        begin
            stepv = (prod_reg + 65535) >>> 16;
        end
        else
        begin
            stepv = prod_reg >>> 16;
        end
        newv = (PW+2)'($signed(oldp_reg)) + (PW+2)'(stepv);
        if (newv[PW+1:PW-1] != {3{newv[PW+1]}})
        begin
            newsat = newv[PW+1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        else
        begin
            newsat = newv[PW-1:0];
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        i_next    = i_reg;
        e_next    = e_reg;
        tri_next  = tri_reg;
        ax_next   = ax_reg;
        us_next   = us_reg;
        oldp_next = oldp_reg;
        prod_next = prod_reg;
        newp_next = newp_reg;
        done_next = 1'b0;
        nb_we     = 1'b0;
        nb_waddr  = i_reg[VA-1:0];
        nb_wdata  = '0;
        nb_raddr  = i_reg[VA-1:0];
        vs_we     = 1'b0;
        vs_waddr  = i_reg[VA-1:0];
        vs_wdata  = newp_reg;
        vs_raddr  = i_reg[VA-1:0];
        ts_raddr  = i_reg[TA-1:0];
        dv_start  = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    i_next = '0;
                    case (cmd.op)
                        lms_pkg::OP_CLR: st_next = S_CLR;
                        lms_pkg::OP_TRI: st_next = S_TRD;
                        lms_pkg::OP_UPD: st_next = S_UREQ;
                        default:         done_next = 1'b1;
                    endcase
                end
            end
            S_CLR:
            begin
                if (i_reg >= TC'(vcount))
                begin
                    st_next = S_IDLE; done_next = 1'b1;
                end
                else
                begin
                    nb_we  = 1'b1;
                    i_next = i_reg + 1'b1;
                end
            end
            S_TRD:
            begin
                if (i_reg >= tcount)
                begin
                    st_next = S_IDLE; done_next = 1'b1;
                end
                else
                begin
                    st_next = S_TWAIT;
                end
            end
            S_TWAIT:
            begin
                tri_next = ts_rdata;
                e_next   = '0;
                st_next  = S_EREQ;
            end
            S_EREQ:
            begin
                nb_raddr = self_i[VA-1:0];
                vs_raddr = oth_i[VA-1:0];
                if (self_i == oth_i)
                begin
                    st_next = S_EADD;
                end
                else
                begin
                    st_next = S_EWAIT;
                end
            end
            S_EWAIT:
            begin
                nb_we    = 1'b1;
                nb_waddr = self_i[VA-1:0];
                nb_wdata = {nb_rdata[NBW-1:3*SW] + 1'b1,
                            sat_add(nb_rdata[3*SW-1:2*SW], vs_rdata[3*PW-1:2*PW]),
                            sat_add(nb_rdata[2*SW-1:SW],   vs_rdata[2*PW-1:PW]),
                            sat_add(nb_rdata[SW-1:0],      vs_rdata[PW-1:0])};
                st_next  = S_EADD;
            end
            S_EADD:
            begin
                if (e_reg == 3'd5)
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_TRD;
                end
                else
                begin
                    e_next  = e_reg + 1'b1;
                    st_next = S_EREQ;
                end
            end
            S_UREQ:
            begin
                if (i_reg >= TC'(vcount))
                begin
                    st_next = S_IDLE; done_next = 1'b1;
                end
                else
                begin
                    st_next = S_UWAIT;
                end
            end
            S_UWAIT:
            begin
                newp_next = vs_rdata;
                ax_next   = '0;
                us_next   = '0;
                if (!mark_rdata || nb_rdata[NBW-1:3*SW] == '0)
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_UREQ;
                end
                else
                begin
                    st_next = S_UCALC;
                end
            end
            S_UCALC:
            begin
                // sub-steps: 0 start divide, 1 wait, 2 multiply, 3 write axis, 4 store vertex
                case (us_reg)
                    3'd0:
                    begin
                        oldp_next = $signed(newp_reg[ax_reg*PW +: PW]);
                        dv_start  = 1'b1;
                        us_next   = 3'd1;
                    end
                    3'd1:
                    begin
                        if (dv_done)
                        begin
                            us_next = 3'd2;
                        end
                    end
                    3'd2:
                    begin
                        prod_next = (FW+PW+3)'($signed({1'b0, factor})) *
                                    (FW+PW+3)'(diff);
                        us_next   = 3'd3;
                    end
                    default:
                    begin
                        newp_next[ax_reg*PW +: PW] = newsat;
                        us_next = 3'd0;
                        if (ax_reg == 2'd2)
                        begin
                            us_next = 3'd4;
                            st_next = S_UCALC;
                        end
                        else
                        begin
                            ax_next = ax_reg + 1'b1;
                        end
                        if (us_reg == 3'd4)
                        begin
                            vs_we   = 1'b1;
                            i_next  = i_reg + 1'b1;
                            us_next = 3'd0;
                            st_next = S_UREQ;
                        end
                    end
                endcase
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            i_reg    <= '0;
            e_reg    <= '0;
            ax_reg   <= '0;
            us_reg   <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            i_reg    <= i_next;
            e_reg    <= e_next;
            ax_reg   <= ax_next;
            us_reg   <= us_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg  <= tri_next;
        oldp_reg <= oldp_next;
        prod_reg <= prod_next;
        newp_reg <= newp_next;
    end

    assign stat.done = done_reg;
    assign busy      = (st_reg != S_IDLE);

endmodule

FILE: rtl/core/lms_ctrl.sv
// ----------------------------------------------------------------------------
// Mesh smoothing controller
// Decodes requests, keeps the counts and sequences the passes of a run.
// ----------------------------------------------------------------------------
module lms_ctrl #(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_TRIANGLES = 8192
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [lms_pkg::CMD_W-1:0]      cmd,
    input  logic [lms_pkg::IDX_W-1:0]      corner_a,
    input  logic [lms_pkg::IDX_W-1:0]      corner_b,
    input  logic [lms_pkg::IDX_W-1:0]      corner_c,
    input  logic [lms_pkg::IDX_W-1:0]      read_index,
    input  logic [lms_pkg::ITER_W-1:0]     iters,
    output logic                           in_ready,
    output logic                           res_valid,
    input  logic                           res_free,
    output logic [lms_pkg::STATUS_W-1:0]   res_status,
    output logic                           res_read,
    output logic                           vs_load,
    output logic                           ts_load,
    output logic [$clog2(MAX_VERTICES+1)-1:0]  vcount,
    output logic [$clog2(MAX_TRIANGLES+1)-1:0] tcount,
    output logic                           run_active,
    output lms_pkg::dp_cmd_t               dcmd,
    input  lms_pkg::dp_stat_t              dstat
);

    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int TC = $clog2(MAX_TRIANGLES + 1);

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_RD   = 6'b000010,
        C_CLR  = 6'b000100,
        C_TRI  = 6'b001000,
        C_UPD  = 6'b010000,
        C_OUT  = 6'b100000
    } cst_t;

    cst_t                      st_reg, st_next;
    logic [VC-1:0]             vc_reg, vc_next;
    logic [TC-1:0]             tc_reg, tc_next;
    logic [lms_pkg::ITER_W-1:0] it_reg, it_next;
    logic [lms_pkg::STATUS_W-1:0] sts_reg, sts_next;
    logic                      rd_reg, rd_next;
    logic                      wait_reg, wait_next;

    always_comb
    begin
        st_next   = st_reg;
        vc_next   = vc_reg;
        tc_next   = tc_reg;
        it_next   = it_reg;
        sts_next  = sts_reg;
        rd_next   = rd_reg;
        wait_next = 1'b0;
        vs_load   = 1'b0;
        ts_load   = 1'b0;
        dcmd.op    = lms_pkg::OP_NONE;
        dcmd.start = 1'b0;
        case (st_reg)
            C_IDLE:
            begin
                if (in_fire)
                begin
                    sts_next = lms_pkg::ST_OK;
                    rd_next  = 1'b0;
                    st_next  = C_OUT;
                    case (cmd)
                        lms_pkg::CMD_CLEAR:
                        begin
                            vc_next = '0;
                            tc_next = '0;
                        end
                        lms_pkg::CMD_ADDV:
                        begin
                            if (vc_reg >= VC'(MAX_VERTICES))
                            begin
                                sts_next = lms_pkg::ST_VFULL;
                            end
                            else
                            begin
                                vs_load = 1'b1;
                                vc_next = vc_reg + 1'b1;
                            end
                        end
                        lms_pkg::CMD_ADDT:
                        begin
                            if (tc_reg >= TC'(MAX_TRIANGLES))
                            begin
                                sts_next = lms_pkg::ST_TFULL;
                            end
                            else if (VC'(corner_a) >= vc_reg || VC'(corner_b) >= vc_reg ||
                                     VC'(corner_c) >= vc_reg)
                            begin
                                sts_next = lms_pkg::ST_BADCORN;
                            end
                            else
                            begin
                                ts_load = 1'b1;
                                tc_next = tc_reg + 1'b1;
                            end
                        end
                        lms_pkg::CMD_RUN:
                        begin
                            it_next = iters;
                            if (iters != '0 && vc_reg != '0)
                            begin
                                st_next   = C_CLR;
                                wait_next = 1'b0;
                            end
                        end
                        lms_pkg::CMD_READ:
                        begin
                            if (VC'(read_index) >= vc_reg)
                            begin
                                sts_next = lms_pkg::ST_BADREAD;
                            end
                            else
                            begin
                                rd_next = 1'b1;
                                st_next = C_RD;
                            end
                        end
                        default:
                        begin
                            sts_next = lms_pkg::ST_OK;
                        end
                    endcase
                end
            end
            C_RD:
            begin
                st_next = C_OUT;
            end
            C_CLR, C_TRI, C_UPD:
            begin
                if (!wait_reg)
                begin
                    dcmd.start = 1'b1;
                    dcmd.op    = (st_reg == C_CLR) ? lms_pkg::OP_CLR :
                                 (st_reg == C_TRI) ? lms_pkg::OP_TRI : lms_pkg::OP_UPD;
                    wait_next  = 1'b1;
                end
                else if (dstat.done)
                begin
                    if (st_reg == C_CLR)
                    begin
                        st_next = C_TRI;
                    end
                    else if (st_reg == C_TRI)
                    begin
                        st_next = C_UPD;
                    end
                    else
                    begin
                        it_next = it_reg - 1'b1;
                        st_next = (it_reg == lms_pkg::ITER_W'(1)) ? C_OUT : C_CLR;
                    end
                end
                else
                begin
                    wait_next = 1'b1;
                end
            end
            C_OUT:
            begin
                if (res_free)
                begin
                    st_next = C_IDLE;
                end
            end
            default:
            begin
                st_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_IDLE;
            vc_reg   <= '0;
            tc_reg   <= '0;
            it_reg   <= '0;
            sts_reg  <= '0;
            rd_reg   <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            vc_reg   <= vc_next;
            tc_reg   <= tc_next;
            it_reg   <= it_next;
            sts_reg  <= sts_next;
            rd_reg   <= rd_next;
            wait_reg <= wait_next;
        end
    end

    assign in_ready   = (st_reg == C_IDLE);
    assign res_valid  = (st_reg == C_OUT);
    assign res_status = sts_reg;
    assign res_read   = rd_reg;
    assign vcount     = vc_reg;
    assign tcount     = tc_reg;
    assign run_active = (st_reg == C_CLR) || (st_reg == C_TRI) || (st_reg == C_UPD);

endmodule

FILE: rtl/core/laplacian_mesh_smoothing_unit.sv
// ----------------------------------------------------------------------------
// Laplacian mesh smoothing unit
// Loads a triangle mesh and runs Jacobi Laplacian smoothing passes on it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         request: cmd in tuser, other fields in tdata
//  m_axis    out        result: status in tuser, position and counts in tdata
//  cfg       in         register index and write data
//
//  Each pass clears the sums, scans the triangles and updates marked vertices with neighbours.
//  Pass time is set by the shared neighbour sum memory and the bit-serial divider.
//  Reset clears counts and control; stores are undefined until written.
//  A result held on m_axis blocks the next request.
// ----------------------------------------------------------------------------
module laplacian_mesh_smoothing_unit #(
    parameter int MAX_VERTICES  = 4096,
    parameter int MAX_TRIANGLES = 8192,
    parameter int SUM_WIDTH     = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, smooth_flag, corner_a, corner_b, corner_c, read_index, pad
    input  logic [151:0] s_axis_tdata,
    // cmd
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, vertices_held, triangles_held, pad
    output logic [127:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int TA = $clog2(MAX_TRIANGLES);
    localparam int VC = $clog2(MAX_VERTICES + 1);
    localparam int TC = $clog2(MAX_TRIANGLES + 1);
    localparam int PW = lms_pkg::POS_W;
    localparam int IW = lms_pkg::IDX_W;

    logic [lms_pkg::FACT_W-1:0] factor_reg;
    logic [lms_pkg::ITER_W-1:0] iter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= 17'd32768;
            iter_reg   <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lms_pkg::REG_FACTOR: factor_reg <= cfg_data;
                lms_pkg::REG_ITER:   iter_reg   <= cfg_data[lms_pkg::ITER_W-1:0];
                default:             factor_reg <= factor_reg;
            endcase
        end
    end

    logic [PW-1:0] pos_x, pos_y, pos_z;
    logic          smooth_flag;
    logic [IW-1:0] corner_a, corner_b, corner_c, read_index;

    assign pos_x       = s_axis_tdata[31:0];
    assign pos_y       = s_axis_tdata[63:32];
    assign pos_z       = s_axis_tdata[95:64];
    assign smooth_flag = s_axis_tdata[96];
    assign corner_a    = s_axis_tdata[108:97];
    assign corner_b    = s_axis_tdata[120:109];
    assign corner_c    = s_axis_tdata[132:121];
    assign read_index  = s_axis_tdata[144:133];

    logic in_fire;
    logic vs_load, ts_load, res_read, run_active, dp_busy;
    logic [lms_pkg::STATUS_W-1:0] res_status;
    logic [VC-1:0] vcount;
    logic [TC-1:0] tcount;
    lms_pkg::dp_cmd_t  dcmd;
    lms_pkg::dp_stat_t dstat;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    lms_ctrl #(.MAX_VERTICES(MAX_VERTICES), .MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .cmd       (s_axis_tuser),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .read_index(read_index),
        .iters     (iter_reg),
        .in_ready  (s_axis_tready),
        .res_valid (m_axis_tvalid),
        .res_free  (m_axis_tready),
        .res_status(res_status),
        .res_read  (res_read),
        .vs_load   (vs_load),
        .ts_load   (ts_load),
        .vcount    (vcount),
        .tcount    (tcount),
        .run_active(run_active),
        .dcmd      (dcmd),
        .dstat     (dstat)
    );

    logic          dp_vs_we;
    logic [VA-1:0] dp_vs_waddr, dp_vs_raddr;
    logic [3*PW-1:0] dp_vs_wdata, vs_rdata;
    logic [TA-1:0] dp_ts_raddr;
    logic [3*IW-1:0] ts_rdata;
    logic          mark_rdata;

    lms_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dcmd),
        .stat      (dstat),
        .vcount    (vcount),
        .tcount    (tcount),
        .factor    (factor_reg),
        .vs_we     (dp_vs_we),
        .vs_waddr  (dp_vs_waddr),
        .vs_wdata  (dp_vs_wdata),
        .vs_raddr  (dp_vs_raddr),
        .vs_rdata  (vs_rdata),
        .mark_rdata(mark_rdata),
        .ts_raddr  (dp_ts_raddr),
        .ts_rdata  (ts_rdata),
        .busy      (dp_busy)
    );

    logic          vs_we;
    logic [VA-1:0] vs_waddr, vs_raddr;
    logic [3*PW-1:0] vs_wdata;

    assign vs_we    = vs_load | dp_vs_we;
    assign vs_waddr = vs_load ? vcount[VA-1:0] : dp_vs_waddr;
    assign vs_wdata = vs_load ? {pos_z, pos_y, pos_x} : dp_vs_wdata;
    assign vs_raddr = run_active ? dp_vs_raddr : read_index[VA-1:0];

    lms_ram #(.WIDTH(3*PW), .DEPTH(MAX_VERTICES)) u_vs_ram (
        .clk  (clk),
        .we   (vs_we),
        .waddr(vs_waddr),
        .wdata(vs_wdata),
        .raddr(vs_raddr),
        .rdata(vs_rdata)
    );

    lms_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_mark_ram (
        .clk  (clk),
        .we   (vs_load),
        .waddr(vcount[VA-1:0]),
        .wdata(smooth_flag),
        .raddr(dp_vs_raddr),
        .rdata(mark_rdata)
    );

    lms_ram #(.WIDTH(3*IW), .DEPTH(MAX_TRIANGLES)) u_ts_ram (
        .clk  (clk),
        .we   (ts_load),
        .waddr(tcount[TA-1:0]),
        .wdata({corner_c, corner_b, corner_a}),
        .raddr(dp_ts_raddr),
        .rdata(ts_rdata)
    );

    // Read data is captured once, the cycle after every accepted request; only a read shows it.
    logic [3*PW-1:0] rd_reg;
    logic            cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            rd_reg <= vs_rdata;
        end
    end

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {5'b0, TC'(tcount), VC'(vcount),
                           res_read ? rd_reg : {3*PW{1'b0}}};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        run_active |-> !s_axis_tready)
        else $error("request taken during a run");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !run_active)
        else $error("result shown while passes run");
    a_dp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !dp_busy)
        else $error("datapath busy while a result is shown");
    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        vcount <= VC'(MAX_VERTICES))
        else $error("vertex count beyond store");
    a_load_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(vs_load && dp_vs_we))
        else $error("vertex store write clash");

endmodule

FILE: sim/laplacian_mesh_smoothing_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laplacian mesh smoothing unit testbench
// Loads meshes, runs smoothing passes and reads vertices back, with random
// idle gaps on the request side and random stalls on the result side. Every
// result is checked against an in-bench model of the vertex and triangle
// stores and the Jacobi smoothing arithmetic.
// ----------------------------------------------------------------------------
module laplacian_mesh_smoothing_unit_test;

    localparam int VERT_DEPTH   = 4096;
    localparam int TRI_DEPTH    = 8192;
    localparam int FACTOR_ONE   = 65536;
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int SETTLE_TIME  = 60;

    typedef struct {
        logic [lms_pkg::CMD_W-1:0]  cmd;
        logic [lms_pkg::POS_W-1:0]  px;
        logic [lms_pkg::POS_W-1:0]  py;
        logic [lms_pkg::POS_W-1:0]  pz;
        logic                       mark;
        logic [lms_pkg::IDX_W-1:0]  ca;
        logic [lms_pkg::IDX_W-1:0]  cb;
        logic [lms_pkg::IDX_W-1:0]  cc;
        logic [lms_pkg::IDX_W-1:0]  ridx;
    } mesh_req_t;

    typedef struct {
        logic [lms_pkg::STATUS_W-1:0] status;
        logic [lms_pkg::POS_W-1:0]    ox;
        logic [lms_pkg::POS_W-1:0]    oy;
        logic [lms_pkg::POS_W-1:0]    oz;
        logic [lms_pkg::VCNT_W-1:0]   vheld;
        logic [lms_pkg::TCNT_W-1:0]   theld;
    } mesh_resp_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [16:0]  cfg_data;

    int               vert_pos [VERT_DEPTH][3];
    bit               vert_mark [VERT_DEPTH];
    int unsigned      tri_corner [TRI_DEPTH][3];
    longint           nb_sum [VERT_DEPTH][3];
    int unsigned      nb_cnt [VERT_DEPTH];
    int unsigned      vert_count;
    int unsigned      tri_count;
    logic [lms_pkg::FACT_W-1:0] blend_factor;
    logic [lms_pkg::ITER_W-1:0] pass_count;

    mesh_resp_t pending_results[$];
    int         error_count;
    int         requests_sent;
    int         runs_sent;
    int         reads_checked;
    longint     cycle_count = 0;
    bit         gaps_on;
    bit         stalls_on;
    int         stall_left = 0;

    laplacian_mesh_smoothing_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint clamp_sum(longint v);
        longint hi;
        hi = (64'sd1 <<< 39) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic int clamp_pos(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    task automatic smoothing_pass();
        int unsigned self_idx;
        int unsigned other_idx;
        longint      old_pos;
        longint      avg;
        longint      delta;
        for (int v = 0; v < vert_count; v++)
        begin
            for (int a = 0; a < 3; a++)
                nb_sum[v][a] = 0;
            nb_cnt[v] = 0;
        end
        for (int t = 0; t < tri_count; t++)
            for (int k = 0; k < 3; k++)
            begin
                self_idx = tri_corner[t][k];
                for (int m = 0; m < 3; m++)
                begin
                    other_idx = tri_corner[t][m];
                    if (m != k && other_idx != self_idx)
                    begin
                        for (int a = 0; a < 3; a++)
                            nb_sum[self_idx][a] = clamp_sum(nb_sum[self_idx][a]
                                + longint'(vert_pos[other_idx][a]));
                        nb_cnt[self_idx]++;
                    end
                end
            end
        for (int v = 0; v < vert_count; v++)
            if (vert_mark[v] && nb_cnt[v] != 0)
                for (int a = 0; a < 3; a++)
                begin
                    old_pos = longint'(vert_pos[v][a]);
                    avg = nb_sum[v][a] / longint'(nb_cnt[v]);
                    delta = (longint'(blend_factor) * (avg - old_pos)) / 64'sd65536;
                    vert_pos[v][a] = clamp_pos(old_pos + delta);
                end
    endtask

    task automatic predict_result(input mesh_req_t r, output mesh_resp_t e);
        e = '{default: '0};
        case (r.cmd)
            lms_pkg::CMD_CLEAR:
            begin
                vert_count = 0;
                tri_count = 0;
            end
            lms_pkg::CMD_ADDV:
                if (vert_count >= VERT_DEPTH)
                    e.status = lms_pkg::ST_VFULL;
                else
                begin
                    vert_pos[vert_count][0] = r.px;
                    vert_pos[vert_count][1] = r.py;
                    vert_pos[vert_count][2] = r.pz;
                    vert_mark[vert_count] = r.mark;
                    vert_count++;
                end
            lms_pkg::CMD_ADDT:
                if (tri_count >= TRI_DEPTH)
                    e.status = lms_pkg::ST_TFULL;
                else if (r.ca >= vert_count || r.cb >= vert_count || r.cc >= vert_count)
                    e.status = lms_pkg::ST_BADCORN;
                else
                begin
                    tri_corner[tri_count][0] = 32'(r.ca);
                    tri_corner[tri_count][1] = 32'(r.cb);
                    tri_corner[tri_count][2] = 32'(r.cc);
                    tri_count++;
                end
            lms_pkg::CMD_RUN:
                for (int i = 0; i < pass_count; i++)
                    smoothing_pass();
            lms_pkg::CMD_READ:
                if (r.ridx >= vert_count)
                    e.status = lms_pkg::ST_BADREAD;
                else
                begin
                    e.ox = vert_pos[r.ridx][0];
                    e.oy = vert_pos[r.ridx][1];
                    e.oz = vert_pos[r.ridx][2];
                end
            default:
                ;
        endcase
        e.vheld = vert_count[lms_pkg::VCNT_W-1:0];
        e.theld = tri_count[lms_pkg::TCNT_W-1:0];
    endtask

    task automatic send_request(input mesh_req_t r);
        logic [151:0] packed_req;
        mesh_resp_t   e;
        int           gap;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        packed_req = {7'd0, r.ridx, r.cc, r.cb, r.ca, r.mark, r.pz, r.py, r.px};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= packed_req;
        s_axis_tuser  <= r.cmd;
        do @(posedge clk); while (!s_axis_tready);
        predict_result(r, e);
        pending_results = {pending_results, e};
        requests_sent++;
        if (r.cmd == lms_pkg::CMD_RUN)
            runs_sent++;
    endtask

    task automatic send_cmd(input logic [lms_pkg::CMD_W-1:0] cmd);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = cmd;
        send_request(r);
    endtask

    task automatic add_vertex(input int x, input int y, input int z, input bit mark);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = lms_pkg::CMD_ADDV;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.mark = mark;
        send_request(r);
    endtask

    task automatic add_triangle(input int unsigned a, input int unsigned b,
                                input int unsigned c);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = lms_pkg::CMD_ADDT;
        r.ca = a[lms_pkg::IDX_W-1:0];
        r.cb = b[lms_pkg::IDX_W-1:0];
        r.cc = c[lms_pkg::IDX_W-1:0];
        send_request(r);
    endtask

    task automatic read_vertex(input int unsigned idx);
        mesh_req_t r;
        r = '{default: '0};
        r.cmd = lms_pkg::CMD_READ;
        r.ridx = idx[lms_pkg::IDX_W-1:0];
        send_request(r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [lms_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[16:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == lms_pkg::REG_FACTOR)
            blend_factor = value[lms_pkg::FACT_W-1:0];
        else
            pass_count = value[lms_pkg::ITER_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        mesh_resp_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {29'd0, m_axis_tuser}, 32'd0);
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tuser != e.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(e.status));
                if (m_axis_tdata[31:0] != e.ox)
                    report_mismatch("out_x", m_axis_tdata[31:0], e.ox);
                if (m_axis_tdata[63:32] != e.oy)
                    report_mismatch("out_y", m_axis_tdata[63:32], e.oy);
                if (m_axis_tdata[95:64] != e.oz)
                    report_mismatch("out_z", m_axis_tdata[95:64], e.oz);
                if (m_axis_tdata[108:96] != e.vheld)
                    report_mismatch("vertices_held", 32'(m_axis_tdata[108:96]),
                                    32'(e.vheld));
                if (m_axis_tdata[122:109] != e.theld)
                    report_mismatch("triangles_held", 32'(m_axis_tdata[122:109]),
                                    32'(e.theld));
                reads_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!stalls_on)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= gap_len();
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_empty_mesh();
        read_vertex(0);
        send_cmd(lms_pkg::CMD_RUN);
        send_cmd(lms_pkg::CMD_READ + 3'd1);
        send_cmd(3'd7);
        send_cmd(lms_pkg::CMD_CLEAR);
    endtask

    task automatic test_directed_mesh();
        add_vertex(32'h7fffffff, 32'h80000000, 0, 1'b1);
        add_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
        add_vertex(32'h00010000, -32'sh00030000, 32'h7fffffff, 1'b0);
        add_vertex(32'h12345678, 32'h00000001, 32'h80000000, 1'b1);
        add_vertex(32'h00050000, 32'h00050000, 32'h00050000, 1'b1);
        add_triangle(0, 1, 2);
        add_triangle(1, 3, 3);
        add_triangle(2, 2, 2);
        add_triangle(0, 5, 1);
        add_triangle(4095, 0, 0);
        add_triangle(0, 1, 4095);
        send_cmd(lms_pkg::CMD_RUN);
        for (int v = 0; v < 5; v++)
            read_vertex(v);
        read_vertex(5);
        read_vertex(2047);
        write_register(lms_pkg::REG_FACTOR, FACTOR_ONE);
        write_register(lms_pkg::REG_ITER, 3);
        send_cmd(lms_pkg::CMD_RUN);
        read_vertex(0);
        read_vertex(3);
        write_register(lms_pkg::REG_ITER, 0);
        send_cmd(lms_pkg::CMD_RUN);
        read_vertex(1);
        write_register(lms_pkg::REG_FACTOR, 0);
        write_register(lms_pkg::REG_ITER, 2);
        send_cmd(lms_pkg::CMD_RUN);
        read_vertex(0);
        send_cmd(lms_pkg::CMD_CLEAR);
    endtask

    task automatic test_sum_saturation();
        write_register(lms_pkg::REG_FACTOR, FACTOR_ONE);
        write_register(lms_pkg::REG_ITER, 1);
        add_vertex(32'h80000000, 32'h7fffffff, 0, 1'b1);
        add_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
        add_vertex(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1);
        for (int t = 0; t < 150; t++)
            add_triangle(0, 1, 2);
        send_cmd(lms_pkg::CMD_RUN);
        for (int v = 0; v < 3; v++)
            read_vertex(v);
        send_cmd(lms_pkg::CMD_CLEAR);
    endtask

    task automatic test_max_passes();
        write_register(lms_pkg::REG_FACTOR, 40000);
        write_register(lms_pkg::REG_ITER, 255);
        add_vertex(32'h00100000, 0, -32'sh00100000, 1'b1);
        add_vertex(-32'sh00200000, 32'h00030000, 0, 1'b1);
        add_vertex(0, -32'sh00400000, 32'h00070000, 1'b0);
        add_vertex(32'h00010000, 32'h00010000, 32'h00010000, 1'b1);
        add_triangle(0, 1, 2);
        add_triangle(1, 2, 3);
        send_cmd(lms_pkg::CMD_RUN);
        for (int v = 0; v < 4; v++)
            read_vertex(v);
        send_cmd(lms_pkg::CMD_CLEAR);
    endtask

    task automatic test_random_meshes();
        int start_count;
        int nv;
        int nt;
        int choice;
        int unsigned pos[3];
        start_count = requests_sent;
        while (requests_sent - start_count < 530)
        begin
            choice = $urandom_range(0, 9);
            write_register(lms_pkg::REG_FACTOR, choice == 0 ? 0 : choice == 1 ? FACTOR_ONE
                                       : $urandom_range(0, FACTOR_ONE));
            write_register(lms_pkg::REG_ITER,
                           $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            send_cmd(lms_pkg::CMD_CLEAR);
            nv = $urandom_range(3, 12);
            nt = $urandom_range(1, 16);
            for (int v = 0; v < nv; v++)
            begin
                for (int a = 0; a < 3; a++)
                    pos[a] = $urandom_range(0, 2) == 0 ? $urandom
                           : ($urandom_range(0, 8) - 4) * 65536 + $urandom_range(0, 65535);
                add_vertex(pos[0], pos[1], pos[2], $urandom_range(0, 3) != 0);
            end
            for (int t = 0; t < nt; t++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_triangle($urandom_range(0, nv - 1), $urandom_range(nv, 4095),
                                 $urandom_range(0, nv - 1));
                else
                    add_triangle($urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                                 $urandom_range(0, nv - 1));
            end
            if ($urandom_range(0, 2) == 0)
                send_cmd(lms_pkg::CMD_W'($urandom_range(lms_pkg::CMD_READ + 1, 7)));
            send_cmd(lms_pkg::CMD_RUN);
            for (int v = 0; v < nv; v++)
                read_vertex(v);
            read_vertex($urandom_range(nv, 2047));
            if ($urandom_range(0, 1) == 0)
            begin
                send_cmd(lms_pkg::CMD_RUN);
                read_vertex($urandom_range(0, nv - 1));
            end
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        requests_sent = 0;
        runs_sent = 0;
        reads_checked = 0;
        vert_count = 0;
        tri_count = 0;
        blend_factor = 17'd32768;
        pass_count = 8'd1;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_mesh();
        test_directed_mesh();
        test_sum_saturation();
        test_max_passes();
        test_random_meshes();

        drain_results();
        repeat (SETTLE_TIME) @(posedge clk);
        $display("Sent %0d requests including %0d smoothing runs; %0d results compared.",
                 requests_sent, runs_sent, reads_checked);
        $display("Covered empty and saturating meshes, bad indices, factor and pass extremes.");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
